FILE: rtl/midi_event_emitter_note_off_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// MIDI event emitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_EVENT_EMITTER_NOTE_OFF_SCHEDULER_TOP_DEFINES_SVH
`define MIDI_EVENT_EMITTER_NOTE_OFF_SCHEDULER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MEE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mee assertion failed");

// antecedent implies consequent in the next cycle
`define MEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mee assertion failed");

`endif

FILE: rtl/mee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mee_pkg
// Types and fixed constants of the MIDI event emitter / note-off scheduler.
// ----------------------------------------------------------------------------
package mee_pkg;

	// request codes
	typedef enum logic [2:0] {
		ACT_TIMED     = 3'd0,
		ACT_NOTE_ON   = 3'd1,
		ACT_NOTE_OFF  = 3'd2,
		ACT_CTRL      = 3'd3,
		ACT_BEND      = 3'd4,
		ACT_BLOCK_END = 3'd5,
		ACT_CLEAR     = 3'd6
	} action_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MUL0,
		S_MUL1,
		S_SCHED,
		S_READ,
		S_EVAL,
		S_FLUSH
	} state_t;

	// configuration register indexes
	localparam logic [0:0] REG_OUTPUT_COUNT = 1'b0;
	localparam logic [0:0] REG_SAMPLE_RATE  = 1'b1;

	// MIDI status high nibbles
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CTRL     = 4'hB;
	localparam logic [3:0] NIB_BEND     = 4'hE;

	// encoded single event
	typedef struct packed {
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
		logic       skip;   // timed note with zero velocity
	} evt_t;

	// duration conversion: 24-bit duration times 18-bit rate, two 9-bit digits
	localparam int MUL_DIG = 9;
	localparam int PROD_W  = 42;
	localparam int DS_W    = PROD_W - 16;
	localparam logic [PROD_W-1:0] DUR_ROUND = PROD_W'(32768);

	// scheduled remaining samples: offset plus converted duration
	localparam int REM_W   = DS_W + 1;
	localparam int ENTRY_W = REM_W + 4 + 7;

	localparam int MAX_BLOCK   = 4096;
	localparam int MAX_RESULTS = 32;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);
	localparam int OFF_MAX     = 4095;

endpackage

FILE: rtl/mee_pend_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mee_pend_mem
// Pending note-off table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mee_pend_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 38,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mee_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mee_encode
// Encodes one emit request into MIDI status and data bytes.
// ----------------------------------------------------------------------------
module mee_encode (
	input  mee_pkg::action_t    action,
	input  logic signed [7:0]   out_index,
	input  logic signed [15:0]  pitch,
	input  logic signed [15:0]  velocity,
	input  logic signed [17:0]  control_value,
	input  logic [4:0]          output_count,
	output mee_pkg::evt_t       evt
);
	import mee_pkg::*;

	// Q8.8 to 0..127, round half away, negatives to zero
	function automatic logic [6:0] q88_to_7(input logic signed [15:0] v);
		logic [15:0] sum;
		logic [6:0]  res;
		sum = {1'b0, v[14:0]} + 16'd128;
		if (v <= 16'sd0) begin
			res = 7'd0;
		end else if (sum[15:8] > 8'd127) begin
			res = 7'd127;
		end else begin
			res = sum[14:8];
		end
		return res;
	endfunction

	logic [4:0]  cnt;
	logic [3:0]  cnt_m1;
	logic [3:0]  ch;
	logic [6:0]  p7;
	logic [6:0]  v7;
	logic [16:0] cc;
	logic [23:0] cval_sum;
	logic [6:0]  cval;
	logic [17:0] bx;
	logic [32:0] bsum;
	logic [13:0] bw;

	// channel: clamp count to 1..16, index to 0..count-1
	always_comb begin
		if (output_count == 5'd0) begin
			cnt = 5'd1;
		end else if (output_count > 5'd16) begin
			cnt = 5'd16;
		end else begin
			cnt = output_count;
		end
		cnt_m1 = 4'(cnt - 5'd1);
		if (out_index < 8'sd0) begin
			ch = 4'd0;
		end else if (out_index > $signed({4'b0, cnt_m1})) begin
			ch = cnt_m1;
		end else begin
			ch = out_index[3:0];
		end
	end

	assign p7 = q88_to_7(pitch);
	assign v7 = q88_to_7(velocity);

	// controller value: clamp 0..1.0, scale by 127 with rounding
	always_comb begin
		if (control_value < 18'sd0) begin
			cc = 17'd0;
		end else if (control_value > 18'sd65536) begin
			cc = 17'd65536;
		end else begin
			cc = control_value[16:0];
		end
		cval_sum = ({cc, 7'b0} - 24'(cc)) + 24'd32768;
		cval = (cval_sum[23:16] > 8'd127) ? 7'd127 : cval_sum[22:16];
	end

	// bend: clamp -1..1, offset to 0..2, map onto 0..16383 with rounding
	always_comb begin
		if (control_value < -18'sd65536) begin
			bx = 18'd0;
		end else if (control_value > 18'sd65536) begin
			bx = 18'd131072;
		end else begin
			bx = 18'(control_value + 18'sd65536);
		end
		bsum = ({1'b0, bx, 14'b0} - 33'(bx)) + 33'd65536;
		bw = (bsum[32:17] > 16'd16383) ? 14'd16383 : bsum[30:17];
	end

	// event select
	always_comb begin
		evt.skip = 1'b0;
		evt.d1   = p7;
		case (action)
			ACT_TIMED: begin
				evt.status = {NIB_NOTE_ON, ch};
				evt.d2     = v7;
				evt.skip   = (v7 == 7'd0);
			end
			ACT_NOTE_ON: begin
				evt.status = (v7 == 7'd0) ? {NIB_NOTE_OFF, ch} : {NIB_NOTE_ON, ch};
				evt.d2     = v7;
			end
			ACT_CTRL: begin
				evt.status = {NIB_CTRL, ch};
				evt.d2     = cval;
			end
			ACT_BEND: begin
				evt.status = {NIB_BEND, ch};
				evt.d1     = bw[6:0];
				evt.d2     = bw[13:7];
			end
			default: begin
				evt.status = {NIB_NOTE_OFF, ch};
				evt.d2     = 7'd0;
			end
		endcase
	end

endmodule

FILE: rtl/midi_event_emitter_note_off_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_emitter_note_off_scheduler_top
// MIDI event emitter with a note-off schedule table walked at block ends.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only when the sequencer is idle.
// Note on, note off, controller and bend load their event into the output
// register from the execute state, which waits while out_ready holds the
// output register, and then free the input. A timed note shows its note-on
// the same way; then, if the table has room, one shared 24x9 multiplier forms
// duration*sample_rate in two digit steps and the entry is written. A block
// end walks the table through the read and evaluate states for each entry and
// a flush state (none when the table is empty or the length is zero), and
// stalls only when a due note-off must wait for the output register. Clear,
// unknown requests and zero-velocity timed notes go back to idle from execute.
// No clearing pass after reset: the table holds only what has been written below its count.
// ----------------------------------------------------------------------------
module midi_event_emitter_note_off_scheduler_top #(
	parameter int PENDING_CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [17:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [7:0]  out_index,
	input  logic signed [15:0] pitch,
	input  logic signed [15:0] velocity,
	input  logic [23:0]        duration,
	input  logic signed [17:0] control_value,
	input  logic [11:0]        sample_offset,
	input  logic [12:0]        block_length,
	// event channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         status_byte,
	output logic [6:0]         data_first,
	output logic [6:0]         data_second,
	output logic [11:0]        event_offset,
	output logic               last
);
	import mee_pkg::*;

	localparam int IDX_W = (PENDING_CAPACITY > 1) ? $clog2(PENDING_CAPACITY) : 1;
	localparam int CNT_W = $clog2(PENDING_CAPACITY + 1);

	state_t state_q, state_d;

	// configuration registers
	logic [4:0]  output_count_q;
	logic [17:0] sample_rate_q;

	// latched request
	action_t            action_q;
	logic signed [7:0]  out_index_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] velocity_q;
	logic [23:0]        duration_q;
	logic signed [17:0] control_value_q;
	logic [11:0]        offset_q;
	logic [12:0]        len_q;

	// table control
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] keep_q;
	logic [N_W-1:0]   n_q;

	// held due note-off, shown once the next one (or the walk end) is known
	logic        hold_v_q;
	logic [7:0]  hold_status_q;
	logic [6:0]  hold_note_q;
	logic [11:0] hold_off_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  status_byte_q;
	logic [6:0]  data_first_q;
	logic [6:0]  data_second_q;
	logic [11:0] event_offset_q;
	logic        last_q;

	logic          accept;
	logic          out_free;
	evt_t          evt;
	logic [PROD_W-1:0] acc_q;
	logic [MUL_DIG-1:0] mul_b;
	logic [32:0]   mul_p;
	logic [DS_W-1:0]  ds;
	logic [DS_W-1:0]  ds_min;
	logic [REM_W-1:0] rem_new;
	logic [ENTRY_W-1:0] sched_word;
	logic [ENTRY_W-1:0] rd_word;
	logic [REM_W-1:0] ent_rem;
	logic [3:0]    ent_ch;
	logic [6:0]    ent_note;
	logic [REM_W-1:0] len_ext;
	logic          ent_due;
	logic          emit_ok;
	logic          eval_stall;
	logic          walk_end;
	logic [12:0]   len_m1;
	logic [12:0]   eo13;
	logic [11:0]   eo;

	logic              out_load;
	logic [7:0]        ld_status;
	logic [6:0]        ld_d1;
	logic [6:0]        ld_d2;
	logic [11:0]       ld_off;
	logic              ld_last;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic              mem_re;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// request encoder
	mee_encode u_enc (
		.action        (action_q),
		.out_index     (out_index_q),
		.pitch         (pitch_q),
		.velocity      (velocity_q),
		.control_value (control_value_q),
		.output_count  (output_count_q),
		.evt           (evt)
	);

	// shared multiplier: one 9-bit digit of the sample rate per step
	assign mul_b = (state_q == S_MUL0) ? sample_rate_q[MUL_DIG-1:0]
	                                   : sample_rate_q[2*MUL_DIG-1:MUL_DIG];
	assign mul_p = duration_q * mul_b;

	// new schedule entry
	assign ds         = acc_q[PROD_W-1:16];
	assign ds_min     = (ds == '0) ? DS_W'(1) : ds;
	assign rem_new    = REM_W'(ds_min) + REM_W'(offset_q);
	assign sched_word = {rem_new, evt.status[3:0], evt.d1};

	// entry under test during the walk
	assign ent_rem  = rd_word[ENTRY_W-1:11];
	assign ent_ch   = rd_word[10:7];
	assign ent_note = rd_word[6:0];
	assign len_ext  = REM_W'(len_q);
	assign ent_due  = (ent_rem <= len_ext);
	assign emit_ok  = (n_q < N_W'(MAX_RESULTS));
	assign eval_stall = ent_due && emit_ok && hold_v_q && !out_free;
	assign walk_end = (CNT_W'(idx_q + CNT_W'(1)) == count_q);
	assign len_m1   = len_q - 13'd1;
	assign eo13     = (ent_rem < len_ext) ? ent_rem[12:0] : len_m1;
	assign eo       = (eo13 > 13'(OFF_MAX)) ? 12'(OFF_MAX) : eo13[11:0];

	mee_pend_mem #(
		.DEPTH (PENDING_CAPACITY),
		.WIDTH (ENTRY_W),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_word)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (action_q) inside
					ACT_TIMED: begin
						if (evt.skip) begin
							state_d = S_IDLE;
						end else if (out_free) begin
							state_d = (count_q < CNT_W'(PENDING_CAPACITY)) ? S_MUL0 : S_IDLE;
						end
					end
					ACT_NOTE_ON, ACT_NOTE_OFF, ACT_CTRL, ACT_BEND: begin
						if (out_free) begin
							state_d = S_IDLE;
						end
					end
					ACT_BLOCK_END: begin
						state_d = (len_q == '0 || count_q == '0) ? S_IDLE : S_READ;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MUL0:  state_d = S_MUL1;
			S_MUL1:  state_d = S_SCHED;
			S_SCHED: state_d = S_IDLE;
			S_READ:  state_d = S_EVAL;
			S_EVAL: begin
				if (!eval_stall) begin
					state_d = walk_end ? S_FLUSH : S_READ;
				end
			end
			S_FLUSH: begin
				if (!hold_v_q || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_load  = 1'b0;
		ld_status = evt.status;
		ld_d1     = evt.d1;
		ld_d2     = evt.d2;
		ld_off    = offset_q;
		ld_last   = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = sched_word;
		mem_re    = (state_q == S_READ);
		unique case (state_q)
			S_EXEC: begin
				case (action_q) inside
					ACT_TIMED: out_load = out_free && !evt.skip;
					ACT_NOTE_ON, ACT_NOTE_OFF, ACT_CTRL, ACT_BEND: out_load = out_free;
					default: out_load = 1'b0;
				endcase
			end
			S_SCHED: mem_we = 1'b1;
			S_EVAL: begin
				if (ent_due) begin
					// previous due note-off goes out, not the final one
					out_load  = emit_ok && hold_v_q && out_free;
					ld_status = hold_status_q;
					ld_d1     = hold_note_q;
					ld_d2     = 7'd0;
					ld_off    = hold_off_q;
					ld_last   = 1'b0;
				end else begin
					// compact surviving entry toward the front
					mem_we    = 1'b1;
					mem_waddr = keep_q[IDX_W-1:0];
					mem_wdata = {ent_rem - len_ext, ent_ch, ent_note};
				end
			end
			S_FLUSH: begin
				out_load  = hold_v_q && out_free;
				ld_status = hold_status_q;
				ld_d1     = hold_note_q;
				ld_d2     = 7'd0;
				ld_off    = hold_off_q;
				ld_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			output_count_q <= 5'd1;
			sample_rate_q  <= 18'd44100;
			count_q        <= '0;
			idx_q          <= '0;
			keep_q         <= '0;
			n_q            <= '0;
			hold_v_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OUTPUT_COUNT: output_count_q <= cfg_data[4:0];
					REG_SAMPLE_RATE:  sample_rate_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					if (action_q == ACT_CLEAR) begin
						count_q <= '0;
					end
					if (action_q == ACT_BLOCK_END) begin
						idx_q    <= '0;
						keep_q   <= '0;
						n_q      <= '0;
						hold_v_q <= 1'b0;
					end
				end
				S_SCHED: count_q <= CNT_W'(count_q + CNT_W'(1));
				S_EVAL: begin
					if (!eval_stall) begin
						idx_q <= CNT_W'(idx_q + CNT_W'(1));
						if (!ent_due) begin
							keep_q <= CNT_W'(keep_q + CNT_W'(1));
						end else if (emit_ok) begin
							n_q      <= N_W'(n_q + N_W'(1));
							hold_v_q <= 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (!hold_v_q || out_free) begin
						count_q  <= keep_q;
						hold_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q        <= action_t'(action);
			out_index_q     <= out_index;
			pitch_q         <= pitch;
			velocity_q      <= velocity;
			duration_q      <= duration;
			control_value_q <= control_value;
			offset_q        <= sample_offset;
			len_q           <= (32'(block_length) > MAX_BLOCK) ? 13'(MAX_BLOCK) : block_length;
		end
		if (state_q == S_MUL0) begin
			acc_q <= PROD_W'(mul_p) + DUR_ROUND;
		end
		if (state_q == S_MUL1) begin
			acc_q <= acc_q + (PROD_W'(mul_p) << MUL_DIG);
		end
		if (state_q == S_EVAL && !eval_stall && ent_due && emit_ok) begin
			hold_status_q <= {NIB_NOTE_OFF, ent_ch};
			hold_note_q   <= ent_note;
			hold_off_q    <= eo;
		end
		if (out_load) begin
			status_byte_q  <= ld_status;
			data_first_q   <= ld_d1;
			data_second_q  <= ld_d2;
			event_offset_q <= ld_off;
			last_q         <= ld_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status_byte  = status_byte_q;
	assign data_first   = data_first_q;
	assign data_second  = data_second_q;
	assign event_offset = event_offset_q;
	assign last         = last_q;

endmodule

FILE: rtl/mee_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mee_checker
// Port-level checks on the MIDI event emitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_event_emitter_note_off_scheduler_top_defines.svh"

module mee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  status_byte,
	input logic [6:0]  data_first,
	input logic [6:0]  data_second,
	input logic [11:0] event_offset,
	input logic        last
);
	import mee_pkg::*;

	// one request at a time: busy right after a transaction
	`MEE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a stalled event holds
	`MEE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status_byte) && $stable(data_first) && $stable(data_second) && $stable(event_offset) && $stable(last))

	// only the four supported status kinds leave the block
	`MEE_ASSERT_SAME(a_status_kind, out_valid, status_byte[7:4] == NIB_NOTE_OFF || status_byte[7:4] == NIB_NOTE_ON || status_byte[7:4] == NIB_CTRL || status_byte[7:4] == NIB_BEND)

	// note-off carries zero velocity, note-on never does
	`MEE_ASSERT_SAME(a_off_zero_vel, out_valid && status_byte[7:4] == NIB_NOTE_OFF, data_second == 7'd0)
	`MEE_ASSERT_SAME(a_on_nonzero_vel, out_valid && status_byte[7:4] == NIB_NOTE_ON, data_second != 7'd0)

endmodule

bind midi_event_emitter_note_off_scheduler_top mee_checker u_mee_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status_byte  (status_byte),
	.data_first   (data_first),
	.data_second  (data_second),
	.event_offset (event_offset),
	.last         (last)
);
